/* rtl/cks_pkg.sv */
// Shared types, constants and microcode encodings for the cocktail sort block.
// Used by cks_urom, cks_seq, cks_dpath and cocktail_sort_records; no dependencies.
package cks_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam int KEY_W = 16;
	localparam int TAG_W = 32;
	localparam int POS_W = 6;

	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] count_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} rec_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_INIT,
		ST_DN_HEAD,
		ST_DN_CMP,
		ST_DN_TAIL,
		ST_UP_HEAD,
		ST_UP_CMP,
		ST_UP_TAIL,
		ST_EM_INIT,
		ST_EM_RD,
		ST_EM_OUT,
		ST_FIN
	} step_t;

	typedef enum logic [2:0] {
		B_IDX,
		B_CNT,
		B_LM,
		B_RM,
		B_ZERO
	} base_t;

	typedef enum logic [1:0] {
		OFF_Z  = 2'b00,
		OFF_P1 = 2'b01,
		OFF_M2 = 2'b10,
		OFF_M1 = 2'b11
	} off_t;

	typedef enum logic [1:0] {
		WD_IN,
		WD_CARRY,
		WD_CMP
	} wdat_t;

	typedef enum logic [1:0] {
		CA_HOLD,
		CA_RD,
		CA_CMP
	} carry_t;

	typedef enum logic [1:0] {
		LM_HOLD,
		LM_ONE,
		LM_INC
	} lm_op_t;

	typedef enum logic [1:0] {
		RM_HOLD,
		RM_CNT_M1,
		RM_DEC
	} rm_op_t;

	typedef enum logic [3:0] {
		C_ALWAYS,
		C_NEVER,
		C_NOT_LAST,
		C_FEW,
		C_IDX_NE_LM,
		C_IDX_NE_RM,
		C_LM_GE_RM,
		C_LM_LT_RM,
		C_NOT_END
	} cond_t;

	typedef struct packed {
		logic   wait_in;
		logic   wait_out;
		logic   ld;
		logic   rd_en;
		base_t  rd_base;
		off_t   rd_off;
		logic   wr_en;
		base_t  wr_base;
		off_t   wr_off;
		wdat_t  wr_data;
		carry_t carry_op;
		logic   cmp_up;
		logic   idx_we;
		base_t  idx_base;
		off_t   idx_off;
		lm_op_t lm_op;
		rm_op_t rm_op;
		logic   emit;
		logic   finish;
		cond_t  cond;
		step_t  target;
	} ctrl_t;

	typedef struct packed {
		logic few;
		logic idx_eq_lm;
		logic idx_eq_rm;
		logic lm_lt_rm;
		logic at_end;
		logic out_busy;
	} stat_t;

endpackage

/* rtl/cks_urom.sv */
// Microcode table: one control word for each step of the load, sort and emit program.
// Depends on cks_pkg.
module cks_urom (
	input  cks_pkg::step_t step,
	output cks_pkg::ctrl_t cw
);

	always_comb begin
		cw = '0;
		cw.cond = cks_pkg::C_NEVER;
		cw.target = cks_pkg::ST_LOAD;
		case (step)
			cks_pkg::ST_LOAD: begin
				cw.wait_in = 1'b1;
				cw.ld = 1'b1;
				cw.wr_en = 1'b1;
				cw.wr_base = cks_pkg::B_CNT;
				cw.wr_off = cks_pkg::OFF_Z;
				cw.wr_data = cks_pkg::WD_IN;
				cw.cond = cks_pkg::C_NOT_LAST;
				cw.target = cks_pkg::ST_LOAD;
			end
			cks_pkg::ST_INIT: begin
				cw.lm_op = cks_pkg::LM_ONE;
				cw.rm_op = cks_pkg::RM_CNT_M1;
				cw.idx_we = 1'b1;
				cw.idx_base = cks_pkg::B_CNT;
				cw.idx_off = cks_pkg::OFF_M1;
				cw.rd_en = 1'b1;
				cw.rd_base = cks_pkg::B_CNT;
				cw.rd_off = cks_pkg::OFF_M1;
				cw.cond = cks_pkg::C_FEW;
				cw.target = cks_pkg::ST_EM_INIT;
			end
			cks_pkg::ST_DN_HEAD: begin
				cw.carry_op = cks_pkg::CA_RD;
				cw.rd_en = 1'b1;
				cw.rd_base = cks_pkg::B_IDX;
				cw.rd_off = cks_pkg::OFF_M1;
			end
			cks_pkg::ST_DN_CMP: begin
				cw.wr_en = 1'b1;
				cw.wr_base = cks_pkg::B_IDX;
				cw.wr_off = cks_pkg::OFF_Z;
				cw.wr_data = cks_pkg::WD_CMP;
				cw.carry_op = cks_pkg::CA_CMP;
				cw.idx_we = 1'b1;
				cw.idx_base = cks_pkg::B_IDX;
				cw.idx_off = cks_pkg::OFF_M1;
				cw.rd_en = 1'b1;
				cw.rd_base = cks_pkg::B_IDX;
				cw.rd_off = cks_pkg::OFF_M2;
				cw.cond = cks_pkg::C_IDX_NE_LM;
				cw.target = cks_pkg::ST_DN_CMP;
			end
			cks_pkg::ST_DN_TAIL: begin
				cw.wr_en = 1'b1;
				cw.wr_base = cks_pkg::B_LM;
				cw.wr_off = cks_pkg::OFF_M1;
				cw.wr_data = cks_pkg::WD_CARRY;
				cw.lm_op = cks_pkg::LM_INC;
				cw.idx_we = 1'b1;
				cw.idx_base = cks_pkg::B_LM;
				cw.idx_off = cks_pkg::OFF_P1;
				cw.rd_en = 1'b1;
				cw.rd_base = cks_pkg::B_LM;
				cw.rd_off = cks_pkg::OFF_Z;
				cw.cond = cks_pkg::C_LM_GE_RM;
				cw.target = cks_pkg::ST_EM_INIT;
			end
			cks_pkg::ST_UP_HEAD: begin
				cw.carry_op = cks_pkg::CA_RD;
				cw.rd_en = 1'b1;
				cw.rd_base = cks_pkg::B_IDX;
				cw.rd_off = cks_pkg::OFF_Z;
			end
			cks_pkg::ST_UP_CMP: begin
				cw.cmp_up = 1'b1;
				cw.wr_en = 1'b1;
				cw.wr_base = cks_pkg::B_IDX;
				cw.wr_off = cks_pkg::OFF_M1;
				cw.wr_data = cks_pkg::WD_CMP;
				cw.carry_op = cks_pkg::CA_CMP;
				cw.idx_we = 1'b1;
				cw.idx_base = cks_pkg::B_IDX;
				cw.idx_off = cks_pkg::OFF_P1;
				cw.rd_en = 1'b1;
				cw.rd_base = cks_pkg::B_IDX;
				cw.rd_off = cks_pkg::OFF_P1;
				cw.cond = cks_pkg::C_IDX_NE_RM;
				cw.target = cks_pkg::ST_UP_CMP;
			end
			cks_pkg::ST_UP_TAIL: begin
				cw.wr_en = 1'b1;
				cw.wr_base = cks_pkg::B_RM;
				cw.wr_off = cks_pkg::OFF_Z;
				cw.wr_data = cks_pkg::WD_CARRY;
				cw.rm_op = cks_pkg::RM_DEC;
				cw.idx_we = 1'b1;
				cw.idx_base = cks_pkg::B_RM;
				cw.idx_off = cks_pkg::OFF_M1;
				cw.rd_en = 1'b1;
				cw.rd_base = cks_pkg::B_RM;
				cw.rd_off = cks_pkg::OFF_M1;
				cw.cond = cks_pkg::C_LM_LT_RM;
				cw.target = cks_pkg::ST_DN_HEAD;
			end
			cks_pkg::ST_EM_INIT: begin
				cw.idx_we = 1'b1;
				cw.idx_base = cks_pkg::B_ZERO;
				cw.idx_off = cks_pkg::OFF_Z;
			end
			cks_pkg::ST_EM_RD: begin
				cw.rd_en = 1'b1;
				cw.rd_base = cks_pkg::B_IDX;
				cw.rd_off = cks_pkg::OFF_Z;
			end
			cks_pkg::ST_EM_OUT: begin
				cw.wait_out = 1'b1;
				cw.emit = 1'b1;
				cw.idx_we = 1'b1;
				cw.idx_base = cks_pkg::B_IDX;
				cw.idx_off = cks_pkg::OFF_P1;
				cw.cond = cks_pkg::C_NOT_END;
				cw.target = cks_pkg::ST_EM_RD;
			end
			cks_pkg::ST_FIN: begin
				cw.finish = 1'b1;
				cw.cond = cks_pkg::C_ALWAYS;
				cw.target = cks_pkg::ST_LOAD;
			end
			default: begin
				cw.cond = cks_pkg::C_ALWAYS;
				cw.target = cks_pkg::ST_LOAD;
			end
		endcase
	end

endmodule

/* rtl/cks_seq.sv */
// Step counter with conditional jumps; reads the microcode table and gates its enables.
// Depends on cks_pkg and cks_urom.
module cks_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rec_valid,
	input  logic           last,
	input  cks_pkg::stat_t st,
	output logic           rec_stall,
	output cks_pkg::ctrl_t ctrl
);

	cks_pkg::step_t upc_q;
	cks_pkg::step_t upc_next;
	cks_pkg::ctrl_t cw;
	logic           go;
	logic           taken;

	cks_urom u_urom (
		.step (upc_q),
		.cw   (cw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= cks_pkg::ST_LOAD;
		end else begin
			upc_q <= upc_next;
		end
	end

	always_comb begin
		go = !(cw.wait_in && !rec_valid) && !(cw.wait_out && st.out_busy);
		case (cw.cond)
			cks_pkg::C_ALWAYS:    taken = 1'b1;
			cks_pkg::C_NEVER:     taken = 1'b0;
			cks_pkg::C_NOT_LAST:  taken = !last;
			cks_pkg::C_FEW:       taken = st.few;
			cks_pkg::C_IDX_NE_LM: taken = !st.idx_eq_lm;
			cks_pkg::C_IDX_NE_RM: taken = !st.idx_eq_rm;
			cks_pkg::C_LM_GE_RM:  taken = !st.lm_lt_rm;
			cks_pkg::C_LM_LT_RM:  taken = st.lm_lt_rm;
			cks_pkg::C_NOT_END:   taken = !st.at_end;
			default:              taken = 1'b0;
		endcase
		if (!go) begin
			upc_next = upc_q;
		end else if (taken) begin
			upc_next = cw.target;
		end else begin
			upc_next = cks_pkg::step_t'(4'(upc_q) + 4'd1);
		end
		ctrl = cw;
		if (!go) begin
			ctrl.ld = 1'b0;
			ctrl.rd_en = 1'b0;
			ctrl.wr_en = 1'b0;
			ctrl.idx_we = 1'b0;
			ctrl.emit = 1'b0;
			ctrl.finish = 1'b0;
			ctrl.carry_op = cks_pkg::CA_HOLD;
			ctrl.lm_op = cks_pkg::LM_HOLD;
			ctrl.rm_op = cks_pkg::RM_HOLD;
		end
		rec_stall = (upc_q != cks_pkg::ST_LOAD);
	end

endmodule

/* rtl/cks_dpath.sv */
// Record memory, carry register, window marks, counters and the result register.
// Driven by control words from cks_seq; depends on cks_pkg.
module cks_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cks_pkg::ctrl_t             ctrl,
	input  logic [cks_pkg::KEY_W-1:0]  key,
	input  logic [cks_pkg::TAG_W-1:0]  tag,
	input  logic                       sorted_stall,
	output cks_pkg::stat_t             st,
	output logic                       sorted_valid,
	output logic [cks_pkg::KEY_W-1:0]  out_key,
	output logic [cks_pkg::TAG_W-1:0]  out_tag,
	output logic [cks_pkg::POS_W-1:0]  position,
	output logic                       overflow,
	output logic                       end_of_run
);

	cks_pkg::rec_t   mem_q [cks_pkg::MAX_RECORDS];
	cks_pkg::rec_t   rd_q;
	cks_pkg::rec_t   carry_q;
	cks_pkg::rec_t   wdata;
	cks_pkg::rec_t   out_rec_q;
	cks_pkg::count_t cnt_q;
	cks_pkg::addr_t  idx_q;
	cks_pkg::addr_t  lm_q;
	cks_pkg::addr_t  rm_q;
	cks_pkg::addr_t  rd_addr;
	cks_pkg::addr_t  wr_addr;
	cks_pkg::addr_t  idx_new;
	logic            ovf_q;
	logic            out_valid_q;
	logic [cks_pkg::POS_W-1:0] out_pos_q;
	logic            out_ovf_q;
	logic            out_end_q;
	logic            full;
	logic            swap;
	logic            we;

	function automatic cks_pkg::addr_t pick(
		input cks_pkg::base_t b,
		input cks_pkg::off_t  o,
		input cks_pkg::addr_t i,
		input cks_pkg::count_t c,
		input cks_pkg::addr_t l,
		input cks_pkg::addr_t r
	);
		cks_pkg::addr_t v;
		case (b)
			cks_pkg::B_IDX: v = i;
			cks_pkg::B_CNT: v = c[cks_pkg::AW-1:0];
			cks_pkg::B_LM:  v = l;
			cks_pkg::B_RM:  v = r;
			default:        v = '0;
		endcase
		case (o)
			cks_pkg::OFF_P1: pick = v + cks_pkg::AW'(1);
			cks_pkg::OFF_M1: pick = v - cks_pkg::AW'(1);
			cks_pkg::OFF_M2: pick = v - cks_pkg::AW'(2);
			default:         pick = v;
		endcase
	endfunction

	always_comb begin
		full = (cnt_q == cks_pkg::CW'(cks_pkg::MAX_RECORDS));
		rd_addr = pick(ctrl.rd_base, ctrl.rd_off, idx_q, cnt_q, lm_q, rm_q);
		wr_addr = pick(ctrl.wr_base, ctrl.wr_off, idx_q, cnt_q, lm_q, rm_q);
		idx_new = pick(ctrl.idx_base, ctrl.idx_off, idx_q, cnt_q, lm_q, rm_q);
		swap = ctrl.cmp_up ? (carry_q.key > rd_q.key) : (rd_q.key > carry_q.key);
		case (ctrl.wr_data)
			cks_pkg::WD_IN:    wdata = '{key: key, tag: tag};
			cks_pkg::WD_CARRY: wdata = carry_q;
			cks_pkg::WD_CMP:   wdata = swap ? rd_q : carry_q;
			default:           wdata = carry_q;
		endcase
		we = ctrl.wr_en && !(ctrl.wr_data == cks_pkg::WD_IN && full);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wdata;
		end
		if (ctrl.rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
		case (ctrl.carry_op)
			cks_pkg::CA_RD:  carry_q <= rd_q;
			cks_pkg::CA_CMP: carry_q <= swap ? carry_q : rd_q;
			default:         carry_q <= carry_q;
		endcase
		if (ctrl.emit) begin
			out_rec_q <= rd_q;
			out_pos_q <= cks_pkg::POS_W'(idx_q);
			out_ovf_q <= ovf_q;
			out_end_q <= st.at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			idx_q <= '0;
			lm_q <= cks_pkg::AW'(1);
			rm_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.finish) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (ctrl.ld) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + cks_pkg::CW'(1);
				end
			end
			if (ctrl.idx_we) begin
				idx_q <= idx_new;
			end
			if (ctrl.finish) begin
				lm_q <= cks_pkg::AW'(1);
			end else if (ctrl.lm_op == cks_pkg::LM_ONE) begin
				lm_q <= cks_pkg::AW'(1);
			end else if (ctrl.lm_op == cks_pkg::LM_INC) begin
				lm_q <= lm_q + cks_pkg::AW'(1);
			end
			if (ctrl.finish) begin
				rm_q <= '0;
			end else if (ctrl.rm_op == cks_pkg::RM_CNT_M1) begin
				rm_q <= cnt_q[cks_pkg::AW-1:0] - cks_pkg::AW'(1);
			end else if (ctrl.rm_op == cks_pkg::RM_DEC) begin
				rm_q <= rm_q - cks_pkg::AW'(1);
			end
			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
			end else begin
				out_valid_q <= out_valid_q && sorted_stall;
			end
		end
	end

	always_comb begin
		st.few = (cnt_q < cks_pkg::CW'(2));
		st.idx_eq_lm = (idx_q == lm_q);
		st.idx_eq_rm = (idx_q == rm_q);
		st.lm_lt_rm = (lm_q < rm_q);
		st.at_end = (cks_pkg::CW'(idx_q) == cnt_q - cks_pkg::CW'(1));
		st.out_busy = out_valid_q && sorted_stall;
	end

	assign sorted_valid = out_valid_q;
	assign out_key = out_rec_q.key;
	assign out_tag = out_rec_q.tag;
	assign position = out_pos_q;
	assign overflow = out_ovf_q;
	assign end_of_run = out_end_q;

endmodule

/* rtl/cocktail_sort_records.sv */
// Cocktail shaker sort of up to 64 keyed records. Loading takes one record per cycle.
// After the last record, a set sorts after one setup step in passes that each have a head
// and a tail step, one compare-swap per cycle through the record memory.
// Results then leave one at a time, each read and then registered, held while the consumer
// stalls; the next set loads after the finish step that follows the last result. Reset clears
// the sequencer, counters and result valid; the record memory keeps its contents and needs no clearing.
module cocktail_sort_records (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rec_valid,
	output logic                       rec_stall,
	input  logic [cks_pkg::KEY_W-1:0]  key,
	input  logic [cks_pkg::TAG_W-1:0]  tag,
	input  logic                       last,
	output logic                       sorted_valid,
	input  logic                       sorted_stall,
	output logic [cks_pkg::KEY_W-1:0]  out_key,
	output logic [cks_pkg::TAG_W-1:0]  out_tag,
	output logic [cks_pkg::POS_W-1:0]  position,
	output logic                       overflow,
	output logic                       end_of_run
);

	cks_pkg::ctrl_t ctrl;
	cks_pkg::stat_t st;
	logic           out_acc;
	logic           mid_run_q;
	logic [cks_pkg::KEY_W-1:0] prev_key_q;
	logic [cks_pkg::POS_W-1:0] prev_pos_q;
	logic           prev_ovf_q;

	cks_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.last      (last),
		.st        (st),
		.rec_stall (rec_stall),
		.ctrl      (ctrl)
	);

	cks_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.key          (key),
		.tag          (tag),
		.sorted_stall (sorted_stall),
		.st           (st),
		.sorted_valid (sorted_valid),
		.out_key      (out_key),
		.out_tag      (out_tag),
		.position     (position),
		.overflow     (overflow),
		.end_of_run   (end_of_run)
	);

	assign out_acc = sorted_valid && !sorted_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_run_q <= 1'b0;
			prev_key_q <= '0;
			prev_pos_q <= '0;
			prev_ovf_q <= 1'b0;
		end else if (out_acc) begin
			mid_run_q <= !end_of_run;
			prev_key_q <= out_key;
			prev_pos_q <= position;
			prev_ovf_q <= overflow;
		end
	end

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && mid_run_q |-> out_key >= prev_key_q && position == prev_pos_q + 6'd1)
		else $error("results of a set are not in ascending order");

	a_first_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !mid_run_q |-> position == '0)
		else $error("first result of a set does not have position zero");

	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && mid_run_q |-> overflow == prev_ovf_q)
		else $error("overflow flag changed within a set");

endmodule
